// ----- sv/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// pre implies post on every clock edge outside reset
`define AST_IMPLIES(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// cond must never be seen outside reset
`define AST_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

`else

`define AST_IMPLIES(label, clk, rst, pre, post, msg)
`define AST_NEVER(label, clk, rst, cond, msg)

`endif

`endif

// ----- sv/necir_pkg.sv -----
package necir_pkg;

   // field widths
   localparam int TIME_BITS     = 16;
   localparam int REG_BITS      = 16;
   localparam int CODE_BITS     = 32;
   localparam int CMD_BITS      = 8;
   localparam int REPEAT_BITS   = 16;
   localparam int COUNT_BITS    = 6;
   localparam int TICK_BITS     = 2;
   localparam int NUM_REGS      = 8;
   localparam int CSR_IDX_BITS  = 3;

   // default stamp width of the free-running timer
   localparam int STAMP_BITS_DEF = 16;

   // edge counter landmarks
   localparam logic [COUNT_BITS-1:0] COUNT_MAX     = 6'd63;
   localparam logic [COUNT_BITS-1:0] START_EDGE    = 6'd2;
   localparam logic [COUNT_BITS-1:0] LAST_BIT_EDGE = 6'd34;
   localparam logic [COUNT_BITS-1:0] REPEAT_EDGE   = 6'd40;

   // idle tick counter
   localparam logic [TICK_BITS-1:0] TICKS_MAX  = 2'd3;
   localparam logic [TICK_BITS-1:0] TICKS_IDLE = 2'd2;

   typedef enum logic {
      OP_EDGE = 1'b0,
      OP_TICK = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_START_MIN  = 3'd0,
      CSR_START_MAX  = 3'd1,
      CSR_ZERO_MIN   = 3'd2,
      CSR_ZERO_MAX   = 3'd3,
      CSR_ONE_MIN    = 3'd4,
      CSR_ONE_MAX    = 3'd5,
      CSR_REPEAT_MIN = 3'd6,
      CSR_REPEAT_MAX = 3'd7
   } csr_index_type;

   localparam logic [REG_BITS-1:0] REG_RESET [NUM_REGS] = '{
      16'd6000, 16'd8000, 16'd450, 16'd700, 16'd800, 16'd1300, 16'd4500, 16'd6000
   };

   typedef enum logic [2:0] {
      PH_IDLE   = 3'b001,
      PH_DECODE = 3'b010,
      PH_REPEAT = 3'b100
   } phase_type;

   // window bounds handed from the register file to the decoder
   typedef struct packed {
      logic [REG_BITS-1:0] start_min;
      logic [REG_BITS-1:0] start_max;
      logic [REG_BITS-1:0] zero_min;
      logic [REG_BITS-1:0] zero_max;
      logic [REG_BITS-1:0] one_min;
      logic [REG_BITS-1:0] one_max;
      logic [REG_BITS-1:0] repeat_min;
      logic [REG_BITS-1:0] repeat_max;
   } csr_regs_type;

endpackage

// ----- sv/necir_ifs.sv -----
// Input channel: captured edges and overflow ticks
interface necir_req_if;
   import necir_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 operation;
   logic [TIME_BITS-1:0] capture_time;
   logic                 line_high;

   modport source (output valid, operation, capture_time, line_high, input ready);
   modport sink   (input valid, operation, capture_time, line_high, output ready);
endinterface

// Result channel: decoded frames and repeats
interface necir_rsp_if;
   import necir_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CODE_BITS-1:0]   frame_code;
   logic [CMD_BITS-1:0]    command_byte;
   logic                   is_repeat;
   logic [REPEAT_BITS-1:0] repeat_total;

   modport source (output valid, frame_code, command_byte, is_repeat, repeat_total,
                   input ready);
   modport sink   (input valid, frame_code, command_byte, is_repeat, repeat_total,
                   output ready);
endinterface

// Configuration write channel
interface necir_csr_if;
   import necir_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [CSR_IDX_BITS-1:0] addr;
   logic [REG_BITS-1:0]     wdata;

   modport source (output valid, addr, wdata, input ready);
   modport sink   (input valid, addr, wdata, output ready);
endinterface

// ----- sv/nec_ir_capture_decoder_unit.sv -----
// NEC IR decoder fed by falling-edge timer stamps and overflow ticks.
// Results pass from the input register through the decode step to the result register.
// Throughput: one input beat per cycle while the result slot is free or being
// taken; the decode step is a single pass between the input and result registers.
// Reset (synchronous, active high) restores window registers to defaults and
// clears all decode state; no clearing pass follows.
`include "assert_macros.svh"

module nec_ir_capture_decoder_unit #(
   parameter int STAMP_BITS = necir_pkg::STAMP_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   necir_req_if.sink  req_chan,
   necir_rsp_if.source rsp_chan,
   necir_csr_if.sink  csr_chan
);
   import necir_pkg::*;

   localparam int CMP_BITS = (STAMP_BITS > REG_BITS) ? STAMP_BITS : REG_BITS;

   csr_regs_type regs;

   necir_csr_regs u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .regs     (regs)
   );

   // exclusive window check at the wider of stamp and register width
   function automatic logic in_win(input logic [STAMP_BITS-1:0] v,
                                   input logic [REG_BITS-1:0]   lo,
                                   input logic [REG_BITS-1:0]   hi);
      logic [CMP_BITS-1:0] ve;
      logic [CMP_BITS-1:0] le;
      logic [CMP_BITS-1:0] he;
      ve = CMP_BITS'(v);
      le = CMP_BITS'(lo);
      he = CMP_BITS'(hi);
      return (ve > le) && (ve < he);
   endfunction

   // input register
   logic                 in_vld_ff;
   op_type               in_op_ff;
   logic [TIME_BITS-1:0] in_time_ff;
   logic                 in_line_ff;

   // result register
   logic                   rsp_vld_ff;
   logic [CODE_BITS-1:0]   rsp_code_ff;
   logic                   rsp_rep_ff;
   logic [REPEAT_BITS-1:0] rsp_total_ff;

   // decode state
   logic [STAMP_BITS-1:0]  prev_ff, prev_in;
   logic [COUNT_BITS-1:0]  ec_ff, ec_in;
   phase_type              phase_ff, phase_in;
   logic [CODE_BITS-1:0]   code_ff, code_in;
   logic [TICK_BITS-1:0]   ticks_ff, ticks_in;
   logic [REPEAT_BITS-1:0] rcnt_ff, rcnt_in;

   logic                            out_free;
   logic                            step;
   logic                            emit;
   logic                            emit_rep;
   logic [STAMP_BITS+TIME_BITS-1:0] stamp_wide;
   logic [STAMP_BITS-1:0]           stamp;
   logic [STAMP_BITS-1:0]           interval;

   // handshake: the held beat moves on whenever the result slot can take it
   assign out_free       = !rsp_vld_ff || rsp_chan.ready;
   assign step           = in_vld_ff && out_free;
   assign req_chan.ready = !in_vld_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_vld_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_op_ff   <= op_type'(req_chan.operation);
         in_time_ff <= req_chan.capture_time;
         in_line_ff <= req_chan.line_high;
      end
   end

   // stamp interval, modulo the timer width
   assign stamp_wide = {{STAMP_BITS{1'b0}}, in_time_ff};
   assign stamp      = stamp_wide[STAMP_BITS-1:0];
   assign interval   = stamp - prev_ff;

   // one decode step
   always_comb begin
      prev_in  = prev_ff;
      ec_in    = ec_ff;
      phase_in = phase_ff;
      code_in  = code_ff;
      ticks_in = ticks_ff;
      rcnt_in  = rcnt_ff;
      emit     = 1'b0;
      emit_rep = 1'b0;
      if (in_op_ff == OP_TICK) begin
         // two idle ticks with the line high drop the frame
         if (in_line_ff) begin
            if (ticks_ff != TICKS_MAX) begin
               ticks_in = ticks_ff + 1'b1;
            end
            if (ticks_in >= TICKS_IDLE) begin
               code_in  = '0;
               phase_in = PH_IDLE;
               ec_in    = '0;
               rcnt_in  = '0;
            end
         end
      end else begin
         ticks_in = '0;
         prev_in  = stamp;
         if (ec_ff != COUNT_MAX) begin
            ec_in = ec_ff + 1'b1;
         end
         if (ec_in == START_EDGE && in_win(interval, regs.start_min, regs.start_max)) begin
            phase_in = PH_DECODE;
         end
         // data bits
         if (ec_in > START_EDGE && phase_in == PH_DECODE) begin
            if (in_win(interval, regs.zero_min, regs.zero_max)) begin
               code_in = {code_ff[CODE_BITS-2:0], 1'b0};
            end else if (in_win(interval, regs.one_min, regs.one_max)) begin
               code_in = {code_ff[CODE_BITS-2:0], 1'b1};
            end else begin
               phase_in = PH_IDLE;
               code_in  = '0;
               ec_in    = '0;
            end
         end
         // last data bit: frame done
         if (ec_in == LAST_BIT_EDGE && phase_in == PH_DECODE) begin
            phase_in = PH_REPEAT;
            emit     = 1'b1;
         end
         // repeat slot
         if (ec_in == REPEAT_EDGE && phase_in == PH_REPEAT) begin
            ec_in = LAST_BIT_EDGE;
            if (in_win(interval, regs.repeat_min, regs.repeat_max)) begin
               rcnt_in  = rcnt_ff + 1'b1;
               emit     = 1'b1;
               emit_rep = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         ec_ff    <= '0;
         phase_ff <= PH_IDLE;
         code_ff  <= '0;
         ticks_ff <= '0;
         rcnt_ff  <= '0;
      end else if (step) begin
         prev_ff  <= prev_in;
         ec_ff    <= ec_in;
         phase_ff <= phase_in;
         code_ff  <= code_in;
         ticks_ff <= ticks_in;
         rcnt_ff  <= rcnt_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (out_free) begin
         rsp_vld_ff <= step && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (step && emit) begin
         rsp_code_ff  <= code_in;
         rsp_rep_ff   <= emit_rep;
         rsp_total_ff <= rcnt_in;
      end
   end

   assign rsp_chan.valid        = rsp_vld_ff;
   assign rsp_chan.frame_code   = rsp_code_ff;
   assign rsp_chan.command_byte = rsp_code_ff[15:8];
   assign rsp_chan.is_repeat    = rsp_rep_ff;
   assign rsp_chan.repeat_total = rsp_total_ff;

   // decode state consistency
   `AST_IMPLIES(a_repeat_count_range, clock, reset, phase_ff == PH_REPEAT, (ec_ff >= LAST_BIT_EDGE) && (ec_ff < REPEAT_EDGE), "repeat phase with edge count out of range")
   `AST_IMPLIES(a_decode_count_range, clock, reset, phase_ff == PH_DECODE, (ec_ff >= START_EDGE) && (ec_ff < LAST_BIT_EDGE), "decode phase with edge count out of range")
   `AST_IMPLIES(a_idle_cleared, clock, reset, ticks_ff >= TICKS_IDLE, (phase_ff == PH_IDLE) && (ec_ff == '0) && (rcnt_ff == '0) && (code_ff == '0), "idle timeout left decode state set")

endmodule

// ----- sv/necir_csr_regs.sv -----
module necir_csr_regs (
   input  logic                   clock,
   input  logic                   reset,
   necir_csr_if.sink              csr_chan,
   output necir_pkg::csr_regs_type regs
);
   import necir_pkg::*;

   logic [REG_BITS-1:0] regs_ff [NUM_REGS];

   // writes are always accepted and registered
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= REG_RESET;
      end else if (csr_chan.valid && csr_chan.ready) begin
         regs_ff[csr_chan.addr] <= csr_chan.wdata;
      end
   end

   assign regs.start_min  = regs_ff[CSR_START_MIN];
   assign regs.start_max  = regs_ff[CSR_START_MAX];
   assign regs.zero_min   = regs_ff[CSR_ZERO_MIN];
   assign regs.zero_max   = regs_ff[CSR_ZERO_MAX];
   assign regs.one_min    = regs_ff[CSR_ONE_MIN];
   assign regs.one_max    = regs_ff[CSR_ONE_MAX];
   assign regs.repeat_min = regs_ff[CSR_REPEAT_MIN];
   assign regs.repeat_max = regs_ff[CSR_REPEAT_MAX];

endmodule
